FILE: design/stt_pkg.sv
// Shared types and constants for the session token table.
// Used by stt_ctrl, stt_dp and the top level session_token_table_with_expiry.
`timescale 1ns / 1ps

package stt_pkg;

  localparam int SESSIONS_DEF = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int TTL_W      = 40;
  localparam int TIME_W     = 63;
  localparam int EXP_W      = 64;
  localparam int WORD_W     = 64;
  localparam int FAIL_W     = 16;
  localparam int BACKOFF_W  = 12;

  localparam int IN_DATA_W  = 448;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 160;
  localparam int OUT_USER_W = 2;

  localparam int BACKOFF_STEP_MS = 250;
  localparam int BACKOFF_CAP_MS  = 4000;

  localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(64'd7200000000);

  localparam logic [CFG_IDX_W-1:0] CFG_ENFORCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PW_HI   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PW_LO   = 2'd3;

  typedef enum logic [1:0] {
    ACT_CHECK  = 2'd0,
    ACT_LOGIN  = 2'd1,
    ACT_LOGOUT = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_EVICT,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    fail_bump;
    logic    fail_clear;
    logic    step;
    logic    evict;
    logic    emit;
    status_e status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] action;
    logic       enforce;
    logic       tok_present;
    logic       pw_present;
    logic       pw_cfg_zero;
    logic       pw_match;
    logic       hit;
    logic       last;
    logic       out_free;
  } stat_t;

endpackage

FILE: design/session_token_table_with_expiry.sv
// Top level of the session token table with expiry.
// Depends on stt_pkg, stt_ctrl and stt_dp; packs the stream channels.
//
// Usage: requests (check, login, logout) enter on the s_axis channel, one
// result per request leaves on the m_axis channel. Configuration (enforce,
// TTL, expected password) is written through cfg_we_i/cfg_idx_i/cfg_data_i
// while no request is in flight.
// Sequence: after acceptance a request passes a decode state, then, where it
// needs one, a scan of one slot per cycle (up to SESSIONS slots, stopping at
// the first hit), an eviction state for a login that finds no free slot, and
// a done state that loads the result register once the output register frees.
// Requests are handled one at a time; the next is accepted in the idle state
// that follows the loading of the result. Slots are scanned one at a time
// through the single shared compare unit.
// Reset empties the table, clears the failure counter and restores the
// configuration defaults. A stalled receiver holds the result in the output
// register; one more request may be accepted and processed meanwhile, and it
// waits in the final state until the register frees.
`timescale 1ns / 1ps

module session_token_table_with_expiry #(
  parameter int SESSIONS = stt_pkg::SESSIONS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [stt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // token_hi, token_lo, password_hi, password_lo, now_us, random_hi,
  // random_lo, zero pad
  input  logic [stt_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // action, token_present, password_present
  input  logic [stt_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // new_token_hi, new_token_lo, backoff_ms, failure_count, zero pad
  output logic [stt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // status
  output logic [stt_pkg::OUT_USER_W-1:0] m_axis_tuser_o
);

  stt_pkg::cmd_t  cmd;
  stt_pkg::stat_t stat;

  logic [1:0]                    out_status;
  logic [127:0]                  out_token;
  logic [stt_pkg::BACKOFF_W-1:0] out_backoff;
  logic [stt_pkg::FAIL_W-1:0]    out_fail;

  stt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  stt_dp #(
    .SESSIONS (SESSIONS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_action_i      (s_axis_tuser_i[1:0]),
    .in_tok_present_i (s_axis_tuser_i[2]),
    .in_token_i       ({s_axis_tdata_i[63:0], s_axis_tdata_i[127:64]}),
    .in_pw_present_i  (s_axis_tuser_i[3]),
    .in_pw_i          ({s_axis_tdata_i[191:128], s_axis_tdata_i[255:192]}),
    .in_now_i         (s_axis_tdata_i[318:256]),
    .in_rnd_i         ({s_axis_tdata_i[382:319], s_axis_tdata_i[446:383]}),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_status_o     (out_status),
    .out_token_o      (out_token),
    .out_backoff_o    (out_backoff),
    .out_fail_o       (out_fail)
  );

  assign m_axis_tuser_o = out_status;
  assign m_axis_tdata_o = {4'b0, out_fail, out_backoff, out_token[63:0], out_token[127:64]};

endmodule

FILE: design/stt_ctrl.sv
// Controller for the session token table: request sequencing state machine.
// Depends on stt_pkg; drives stt_dp through cmd_t and reads stat_t.
`timescale 1ns / 1ps

module stt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  stt_pkg::stat_t stat_i,
  output stt_pkg::cmd_t  cmd_o
);

  stt_pkg::state_e  state_q, state_d;
  stt_pkg::status_e status_q, status_d;

  logic is_login;
  assign is_login = (stat_i.action == stt_pkg::ACT_LOGIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= stt_pkg::S_IDLE;
      status_q <= stt_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stt_pkg::S_IDLE: begin
        if (in_valid_i) state_d = stt_pkg::S_DECODE;
      end
      stt_pkg::S_DECODE: begin
        state_d = stt_pkg::S_DONE;
        case (stat_i.action)
          stt_pkg::ACT_CHECK: begin
            if (stat_i.enforce && stat_i.tok_present) state_d = stt_pkg::S_SCAN;
          end
          stt_pkg::ACT_LOGIN: begin
            if (stat_i.pw_present && !stat_i.pw_cfg_zero && stat_i.pw_match)
              state_d = stt_pkg::S_SCAN;
          end
          stt_pkg::ACT_LOGOUT: begin
            if (stat_i.tok_present) state_d = stt_pkg::S_SCAN;
          end
          default: state_d = stt_pkg::S_DONE;
        endcase
      end
      stt_pkg::S_SCAN: begin
        if (stat_i.hit) state_d = stt_pkg::S_DONE;
        else if (stat_i.last) state_d = is_login ? stt_pkg::S_EVICT : stt_pkg::S_DONE;
      end
      stt_pkg::S_EVICT: state_d = stt_pkg::S_DONE;
      stt_pkg::S_DONE: begin
        if (stat_i.out_free) state_d = stt_pkg::S_IDLE;
      end
      default: state_d = stt_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.status = status_q;
    status_d   = status_q;
    in_ready_o = 1'b0;
    case (state_q)
      stt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      stt_pkg::S_DECODE: begin
        status_d = stt_pkg::ST_OK;
        case (stat_i.action)
          stt_pkg::ACT_CHECK: begin
            if (stat_i.enforce && !stat_i.tok_present) status_d = stt_pkg::ST_REFUSED;
          end
          stt_pkg::ACT_LOGIN: begin
            if (!stat_i.pw_present || stat_i.pw_cfg_zero) begin
              status_d = stt_pkg::ST_INVALID;
            end else if (!stat_i.pw_match) begin
              status_d        = stt_pkg::ST_INVALID;
              cmd_o.fail_bump = 1'b1;
            end else begin
              cmd_o.fail_clear = 1'b1;
            end
          end
          stt_pkg::ACT_LOGOUT: status_d = stt_pkg::ST_OK;
          default: status_d = stt_pkg::ST_INVALID;
        endcase
      end
      stt_pkg::S_SCAN: begin
        cmd_o.step = 1'b1;
        // a check that runs off the end found no live session
        if (!stat_i.hit && stat_i.last && stat_i.action == stt_pkg::ACT_CHECK)
          status_d = stt_pkg::ST_REFUSED;
      end
      stt_pkg::S_EVICT: cmd_o.evict = 1'b1;
      stt_pkg::S_DONE: cmd_o.emit = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: design/stt_dp.sv
// Datapath for the session token table: config registers, slot storage,
// scan index, failure counter and result register. Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_dp #(
  parameter int SESSIONS = stt_pkg::SESSIONS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [stt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [stt_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [1:0]                        in_action_i,
  input  logic                              in_tok_present_i,
  input  logic [2*stt_pkg::WORD_W-1:0]      in_token_i,
  input  logic                              in_pw_present_i,
  input  logic [2*stt_pkg::WORD_W-1:0]      in_pw_i,
  input  logic [stt_pkg::TIME_W-1:0]        in_now_i,
  input  logic [2*stt_pkg::WORD_W-1:0]      in_rnd_i,
  input  stt_pkg::cmd_t                     cmd_i,
  output stt_pkg::stat_t                    stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        out_status_o,
  output logic [2*stt_pkg::WORD_W-1:0]      out_token_o,
  output logic [stt_pkg::BACKOFF_W-1:0]     out_backoff_o,
  output logic [stt_pkg::FAIL_W-1:0]        out_fail_o
);

  localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int CAP_N = stt_pkg::BACKOFF_CAP_MS / stt_pkg::BACKOFF_STEP_MS;
  localparam int TW    = 2 * stt_pkg::WORD_W;

  // configuration
  logic                      enforce_q;
  logic [stt_pkg::TTL_W-1:0] ttl_q;
  logic [TW-1:0]             exp_pw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enforce_q <= 1'b1;
      ttl_q     <= stt_pkg::TTL_RESET;
      exp_pw_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stt_pkg::CFG_ENFORCE: enforce_q <= cfg_data_i[0];
        stt_pkg::CFG_TTL:     ttl_q <= cfg_data_i[stt_pkg::TTL_W-1:0];
        stt_pkg::CFG_PW_HI:   exp_pw_q[TW-1:stt_pkg::WORD_W] <= cfg_data_i;
        stt_pkg::CFG_PW_LO:   exp_pw_q[stt_pkg::WORD_W-1:0] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched request
  logic [1:0]                req_act_q;
  logic                      req_tok_p_q, req_pw_p_q;
  logic [TW-1:0]             req_tok_q, req_pw_q, req_rnd_q;
  logic [stt_pkg::EXP_W-1:0] now_q, sum_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_act_q   <= in_action_i;
      req_tok_p_q <= in_tok_present_i;
      req_pw_p_q  <= in_pw_present_i;
      req_tok_q   <= in_token_i;
      req_pw_q    <= in_pw_i;
      req_rnd_q   <= in_rnd_i;
      now_q       <= {1'b0, in_now_i};
      sum_q       <= {1'b0, in_now_i} + {{(stt_pkg::EXP_W - stt_pkg::TTL_W){1'b0}}, ttl_q};
    end
  end

  // slot storage; a stored token only counts in a match for a valid slot
  logic [SESSIONS-1:0]                     valid_q;
  logic [SESSIONS-1:0][stt_pkg::EXP_W-1:0] expiry_q;
  logic [SESSIONS-1:0][TW-1:0]             token_q;
  logic [IDX_W-1:0]                        idx_q, min_idx_q;
  logic [stt_pkg::EXP_W-1:0]               min_q;

  logic pick_mode, cur_valid, cur_expired, cur_match, hit;
  logic [stt_pkg::EXP_W-1:0] cur_exp;

  assign pick_mode   = (req_act_q == stt_pkg::ACT_LOGIN);
  assign cur_valid   = valid_q[idx_q];
  assign cur_exp     = expiry_q[idx_q];
  assign cur_expired = (cur_exp <= now_q);
  assign cur_match   = (token_q[idx_q] == req_tok_q);
  assign hit = pick_mode ? (!cur_valid || cur_expired)
                         : (cur_valid && !cur_expired && cur_match);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      expiry_q <= '0;
    end else begin
      if (cmd_i.step) begin
        if (!pick_mode) begin
          if (cur_valid && cur_expired) begin
            valid_q[idx_q]  <= 1'b0;
            expiry_q[idx_q] <= '0;
          end else if (hit) begin
            if (req_act_q == stt_pkg::ACT_CHECK) begin
              expiry_q[idx_q] <= sum_q;
            end else begin
              valid_q[idx_q]  <= 1'b0;
              expiry_q[idx_q] <= '0;
            end
          end
        end else if (hit) begin
          valid_q[idx_q]  <= 1'b1;
          expiry_q[idx_q] <= sum_q;
        end
      end
      if (cmd_i.evict) begin
        valid_q[min_idx_q]  <= 1'b1;
        expiry_q[min_idx_q] <= sum_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && pick_mode && hit) token_q[idx_q] <= req_rnd_q;
    if (cmd_i.evict) token_q[min_idx_q] <= req_rnd_q;
    // earliest expiry among live slots seen so far, lowest index on a tie
    if (cmd_i.step && pick_mode && !hit && (idx_q == '0 || cur_exp < min_q)) begin
      min_q     <= cur_exp;
      min_idx_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // failure counter and backoff
  logic [stt_pkg::FAIL_W-1:0]    fail_q, fail_inc;
  logic [stt_pkg::BACKOFF_W-1:0] backoff_q;

  assign fail_inc = (fail_q == '1) ? fail_q : fail_q + stt_pkg::FAIL_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_q <= '0;
    end else if (cmd_i.fail_bump) begin
      fail_q <= fail_inc;
    end else if (cmd_i.fail_clear) begin
      fail_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      backoff_q <= '0;
    end else if (cmd_i.fail_bump) begin
      if (fail_inc >= stt_pkg::FAIL_W'(CAP_N))
        backoff_q <= stt_pkg::BACKOFF_W'(stt_pkg::BACKOFF_CAP_MS);
      else
        backoff_q <= stt_pkg::BACKOFF_W'(fail_inc * stt_pkg::FAIL_W'(stt_pkg::BACKOFF_STEP_MS));
    end
  end

  // result register
  logic                          out_valid_q;
  logic [1:0]                    out_status_q;
  logic [TW-1:0]                 out_token_q;
  logic [stt_pkg::BACKOFF_W-1:0] out_backoff_q;
  logic [stt_pkg::FAIL_W-1:0]    out_fail_q;
  logic                          out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q  <= cmd_i.status;
      out_token_q   <= (pick_mode && cmd_i.status == stt_pkg::ST_OK) ? req_rnd_q : '0;
      out_backoff_q <= backoff_q;
      out_fail_q    <= fail_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_token_o   = out_token_q;
  assign out_backoff_o = out_backoff_q;
  assign out_fail_o    = out_fail_q;

  assign stat_o.action      = req_act_q;
  assign stat_o.enforce     = enforce_q;
  assign stat_o.tok_present = req_tok_p_q;
  assign stat_o.pw_present  = req_pw_p_q;
  assign stat_o.pw_cfg_zero = (exp_pw_q == '0);
  assign stat_o.pw_match    = (req_pw_q == exp_pw_q);
  assign stat_o.hit         = hit;
  assign stat_o.last        = (idx_q == IDX_W'(SESSIONS - 1));
  assign stat_o.out_free    = out_free;

endmodule

FILE: bench/session_token_table_with_expiry_tb.sv
// Self-checking bench for session_token_table_with_expiry: directed and random
// checks, logins and logouts over the stream ports, predicted by a mirror table.
// Depends on stt_pkg and the design sources; reads no files.
`timescale 1ns / 1ps

module session_token_table_with_expiry_tb;
  import stt_pkg::*;

  localparam int NSLOT = SESSIONS_DEF;

  typedef struct {
    action_e     action;
    logic        tok_present;
    logic [63:0] tok_hi;
    logic [63:0] tok_lo;
    logic        pw_present;
    logic [63:0] pw_hi;
    logic [63:0] pw_lo;
    logic [62:0] now_us;
    logic [63:0] rnd_hi;
    logic [63:0] rnd_lo;
  } request_t;

  typedef struct {
    status_e     status;
    logic [63:0] tok_hi;
    logic [63:0] tok_lo;
    logic [11:0] backoff_ms;
    logic [15:0] fail_count;
  } outcome_t;

  // Mirror of the session table plus the queue of outcomes still owed by the block.
  class session_table_mirror;
    bit          cfg_enforce;
    logic [39:0] cfg_ttl;
    logic [63:0] cfg_pw_hi;
    logic [63:0] cfg_pw_lo;
    bit          slot_valid [NSLOT];
    logic [63:0] slot_hi [NSLOT];
    logic [63:0] slot_lo [NSLOT];
    logic [63:0] slot_expiry [NSLOT];
    logic [15:0] failures;
    outcome_t    outcome_q [$];
    int          errors;
    int          n_requests;
    int          n_replies;
    int          n_issued;
    int          n_evicted;
    int          n_aged;
    int          peak_failures;

    function new();
      cfg_enforce = 1'b1;
      cfg_ttl = TTL_RESET;
      cfg_pw_hi = '0;
      cfg_pw_lo = '0;
      for (int i = 0; i < NSLOT; i++) begin
        slot_valid[i] = 1'b0;
        slot_hi[i] = '0;
        slot_lo[i] = '0;
        slot_expiry[i] = '0;
      end
      failures = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
      case (idx)
        CFG_ENFORCE: cfg_enforce = v[0];
        CFG_TTL:     cfg_ttl = v[TTL_W-1:0];
        CFG_PW_HI:   cfg_pw_hi = v;
        CFG_PW_LO:   cfg_pw_lo = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    function void drop_slot(int i);
      slot_valid[i] = 1'b0;
      slot_hi[i] = '0;
      slot_lo[i] = '0;
      slot_expiry[i] = '0;
    endfunction

    // In-order scan; aged-out slots are dropped on the way to the first live hit.
    function int find_live(logic [63:0] hi, logic [63:0] lo, logic [63:0] now);
      for (int i = 0; i < NSLOT; i++) begin
        if (!slot_valid[i]) continue;
        if (slot_expiry[i] <= now) begin
          drop_slot(i);
          n_aged++;
          continue;
        end
        if (slot_hi[i] == hi && slot_lo[i] == lo) return i;
      end
      return -1;
    endfunction

    function void note_request(request_t rq);
      outcome_t    o;
      logic [63:0] now64;
      int          k;
      int          pick;
      int          d;
      o.status = ST_INVALID;
      o.tok_hi = '0;
      o.tok_lo = '0;
      o.backoff_ms = '0;
      now64 = {1'b0, rq.now_us};
      n_requests++;
      case (rq.action)
        ACT_CHECK: begin
          if (!cfg_enforce) begin
            o.status = ST_OK;
          end else if (!rq.tok_present) begin
            o.status = ST_REFUSED;
          end else begin
            k = find_live(rq.tok_hi, rq.tok_lo, now64);
            if (k >= 0) begin
              slot_expiry[k] = now64 + {24'h0, cfg_ttl};
              o.status = ST_OK;
            end else begin
              o.status = ST_REFUSED;
            end
          end
        end
        ACT_LOGIN: begin
          if (!rq.pw_present || (cfg_pw_hi == '0 && cfg_pw_lo == '0)) begin
            o.status = ST_INVALID;
          end else if (rq.pw_hi != cfg_pw_hi || rq.pw_lo != cfg_pw_lo) begin
            if (failures != 16'hFFFF) failures++;
            d = int'(failures) * BACKOFF_STEP_MS;
            if (d > BACKOFF_CAP_MS) d = BACKOFF_CAP_MS;
            o.backoff_ms = 12'(d);
            o.status = ST_INVALID;
          end else begin
            failures = '0;
            pick = -1;
            for (int i = 0; i < NSLOT; i++) begin
              if (!slot_valid[i] || slot_expiry[i] <= now64) begin
                pick = i;
                break;
              end
            end
            if (pick < 0) begin
              // table full of live sessions: earliest expiry goes, lowest index on a tie
              pick = 0;
              n_evicted++;
              for (int i = 1; i < NSLOT; i++)
                if (slot_expiry[i] < slot_expiry[pick]) pick = i;
            end
            slot_valid[pick] = 1'b1;
            slot_hi[pick] = rq.rnd_hi;
            slot_lo[pick] = rq.rnd_lo;
            slot_expiry[pick] = now64 + {24'h0, cfg_ttl};
            o.tok_hi = rq.rnd_hi;
            o.tok_lo = rq.rnd_lo;
            o.status = ST_OK;
            n_issued++;
          end
        end
        ACT_LOGOUT: begin
          if (rq.tok_present) begin
            k = find_live(rq.tok_hi, rq.tok_lo, now64);
            if (k >= 0) drop_slot(k);
          end
          o.status = ST_OK;
        end
        default: ;
      endcase
      o.fail_count = failures;
      if (int'(failures) > peak_failures) peak_failures = failures;
      outcome_q.push_back(o);
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("mismatch in %s of reply %0d: expected %0h, got %0h",
               field, n_replies, want, got);
    endfunction

    function void check_reply(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      outcome_t e;
      if (outcome_q.size() == 0) begin
        report("reply with nothing outstanding", '0, {62'h0, user});
        return;
      end
      e = outcome_q.pop_front();
      n_replies++;
      if (user != e.status) report("status", e.status, user);
      if (data[63:0] != e.tok_hi) report("new_token_hi", e.tok_hi, data[63:0]);
      if (data[127:64] != e.tok_lo) report("new_token_lo", e.tok_lo, data[127:64]);
      if (data[139:128] != e.backoff_ms) report("backoff_ms", e.backoff_ms, data[139:128]);
      if (data[155:140] != e.fail_count) report("failure_count", e.fail_count, data[155:140]);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // token_hi, token_lo, password_hi, password_lo, now_us, random_hi, random_lo, pad
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  // action, token_present, password_present
  logic [IN_USER_W-1:0]  s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // new_token_hi, new_token_lo, backoff_ms, failure_count, pad
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  // status
  logic [OUT_USER_W-1:0] m_axis_tuser_o;

  session_token_table_with_expiry uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  session_table_mirror sb = new();
  request_t            cur_req;
  bit                  idle_on = 1'b1;
  logic [62:0]         clock_us = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i)
    m_axis_tready_i <= !idle_on || ($urandom_range(99) >= 22);

  // replies first: a reply at this edge always belongs to an older request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_reply(m_axis_tdata_o, m_axis_tuser_o);
      if (s_axis_tvalid_i && s_axis_tready_o) sb.note_request(cur_req);
    end
  end

  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic request_t mkreq(action_e a, logic tp, logic [63:0] thi, logic [63:0] tlo,
                                     logic pp, logic [63:0] phi, logic [63:0] plo,
                                     logic [62:0] now, logic [63:0] rhi, logic [63:0] rlo);
    request_t r;
    r.action = a;
    r.tok_present = tp;
    r.tok_hi = thi;
    r.tok_lo = tlo;
    r.pw_present = pp;
    r.pw_hi = phi;
    r.pw_lo = plo;
    r.now_us = now;
    r.rnd_hi = rhi;
    r.rnd_lo = rlo;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance, tvalid still high.
  task automatic send(input request_t r);
    while (idle_on && $urandom_range(99) < 22) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    cur_req = r;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {1'b0, r.rnd_lo, r.rnd_hi, r.now_us, r.pw_lo, r.pw_hi, r.tok_lo, r.tok_hi};
    s_axis_tuser_i <= {r.pw_present, r.tok_present, r.action};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  // idle point for register writes: nothing owed and the pipeline given time to empty
  task automatic quiesce();
    drain();
    repeat (NSLOT + 6) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    sb.write_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic gen_request(input int step_max, output request_t r);
    int roll;
    int k;
    int b;
    int live_idx [$];
    roll = $urandom_range(99);
    r.action = roll < 45 ? ACT_CHECK : (roll < 80 ? ACT_LOGIN : ACT_LOGOUT);
    r.tok_present = ($urandom_range(99) >= 12);
    r.tok_hi = rnd64();
    r.tok_lo = rnd64();
    clock_us += 63'($urandom_range(step_max));
    for (int i = 0; i < NSLOT; i++)
      if (sb.slot_valid[i]) live_idx.push_back(i);
    if (live_idx.size() > 0 && $urandom_range(99) < 70) begin
      k = live_idx[$urandom_range(live_idx.size() - 1)];
      r.tok_hi = sb.slot_hi[k];
      r.tok_lo = sb.slot_lo[k];
      if ($urandom_range(99) < 8) begin
        // near miss: one bit off in one half
        b = $urandom_range(63);
        if ($urandom_range(1)) r.tok_hi[b] = ~r.tok_hi[b];
        else r.tok_lo[b] = ~r.tok_lo[b];
      end
      // land on or just before the expiry instant
      if (!sb.slot_expiry[k][63] && $urandom_range(99) < 10)
        clock_us = sb.slot_expiry[k][62:0] - 63'($urandom_range(1));
    end
    r.pw_present = ($urandom_range(99) >= 12);
    r.pw_hi = sb.cfg_pw_hi;
    r.pw_lo = sb.cfg_pw_lo;
    roll = $urandom_range(99);
    b = $urandom_range(63);
    if (roll < 15) r.pw_hi[b] = ~r.pw_hi[b];
    else if (roll < 30) r.pw_lo[b] = ~r.pw_lo[b];
    else if (roll < 38) begin
      r.pw_hi = rnd64();
      r.pw_lo = rnd64();
    end
    r.rnd_hi = rnd64();
    r.rnd_lo = rnd64();
    if (live_idx.size() > 0 && $urandom_range(99) < 5) begin
      k = live_idx[$urandom_range(live_idx.size() - 1)];
      r.rnd_hi = sb.slot_hi[k];
      r.rnd_lo = sb.slot_lo[k];
    end
    r.now_us = clock_us;
  endtask

  task automatic run_random(int n, int step_max);
    request_t r;
    for (int i = 0; i < n; i++) begin
      gen_request(step_max, r);
      send(r);
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    logic [63:0] tk [6];
    logic [39:0] ttl40;
    logic [62:0] tmax;
    request_t    r;
    tmax = '1;
    for (int i = 0; i < 6; i++) tk[i] = rnd64();

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: defaults, no password configured
    send(mkreq(ACT_CHECK, 0, '0, '0, 0, '0, '0, 63'd0, '0, '0));
    send(mkreq(ACT_CHECK, 1, '1, '1, 0, '0, '0, 63'd5, '0, '0));
    send(mkreq(ACT_LOGIN, 0, '0, '0, 1, '0, '0, 63'd5, '1, '1));
    send(mkreq(ACT_LOGOUT, 0, '0, '0, 0, '0, '0, 63'd6, '0, '0));
    quiesce();
    write_cfg(CFG_PW_HI, '1);
    write_cfg(CFG_PW_LO, '0);
    write_cfg(CFG_TTL, 64'd1);
    send(mkreq(ACT_LOGIN, 0, '0, '0, 0, '1, '0, 63'd10, '0, '0));
    send(mkreq(ACT_LOGIN, 0, '0, '0, 1, '1, 64'd1, 63'd11, '0, '0));
    send(mkreq(ACT_LOGIN, 0, '0, '0, 1, '0, '0, 63'd12, '0, '0));
    send(mkreq(ACT_LOGIN, 0, '0, '0, 1, '1, '0, 63'd100, '1, '0));
    send(mkreq(ACT_CHECK, 1, '1, '0, 0, '0, '0, 63'd100, '0, '0));
    send(mkreq(ACT_CHECK, 1, '1, 64'd1, 0, '0, '0, 63'd100, '0, '0));
    // expiry equal to now counts as expired
    send(mkreq(ACT_CHECK, 1, '1, '0, 0, '0, '0, 63'd101, '0, '0));
    for (int i = 0; i < 5; i++)
      send(mkreq(ACT_LOGIN, 0, '0, '0, 1, '1, '0, 63'd1000, tk[i], ~tk[i]));
    send(mkreq(ACT_LOGOUT, 1, tk[1], ~tk[1], 0, '0, '0, 63'd1000, '0, '0));
    send(mkreq(ACT_CHECK, 1, tk[1], ~tk[1], 0, '0, '0, 63'd1000, '0, '0));
    send(mkreq(ACT_LOGIN, 0, '0, '0, 1, '1, '0, 63'd1000, tk[5], tk[5]));
    send(mkreq(ACT_CHECK, 1, tk[4], ~tk[4], 0, '0, '0, 63'd1000, '0, '0));
    quiesce();
    write_cfg(CFG_ENFORCE, 64'd0);
    write_cfg(CFG_TTL, 64'hFF_FFFF_FFFF);
    write_cfg(CFG_PW_LO, '1);
    send(mkreq(ACT_CHECK, 0, '0, '0, 0, '0, '0, tmax, '0, '0));
    send(mkreq(ACT_LOGIN, 0, '0, '0, 1, '1, '1, tmax, '0, '0));
    send(mkreq(ACT_CHECK, 1, rnd64(), rnd64(), 0, '0, '0, tmax, '0, '0));
    quiesce();
    write_cfg(CFG_ENFORCE, 64'd1);
    send(mkreq(ACT_CHECK, 1, '0, '0, 0, '0, '0, tmax, '0, '0));
    send(mkreq(ACT_LOGOUT, 1, '0, '0, 0, '0, '0, tmax, '0, '0));

    // random: short TTL, time from zero
    quiesce();
    write_cfg(CFG_TTL, 64'd600);
    write_cfg(CFG_PW_HI, rnd64());
    write_cfg(CFG_PW_LO, rnd64());
    clock_us = '0;
    run_random(100, 200);

    // random: wide TTL, time near the top of the range
    quiesce();
    ttl40 = 40'(rnd64());
    if (ttl40 == '0) ttl40 = 40'd1;
    write_cfg(CFG_TTL, {24'h0, ttl40});
    write_cfg(CFG_PW_HI, rnd64());
    write_cfg(CFG_PW_LO, rnd64());
    clock_us = 63'h6000_0000_0000_0000 + 63'({$urandom, 28'h0});
    run_random(90, 1 << 20);

    // random: enforcement off, tiny TTL
    quiesce();
    write_cfg(CFG_ENFORCE, 64'd0);
    write_cfg(CFG_TTL, 64'($urandom_range(1, 50)));
    clock_us = 63'($urandom);
    run_random(80, 30);

    // random: password only in the low word, both sides never idle
    quiesce();
    write_cfg(CFG_ENFORCE, 64'd1);
    write_cfg(CFG_TTL, 64'd2000);
    write_cfg(CFG_PW_HI, '0);
    write_cfg(CFG_PW_LO, rnd64() | 64'd1);
    idle_on = 1'b0;
    run_random(90, 300);

    // failure counter run past the backoff cap, then a good login clears it
    quiesce();
    for (int i = 0; i < 20; i++) begin
      clock_us += 63'd1;
      send(mkreq(ACT_LOGIN, 0, '0, '0, 1, ~sb.cfg_pw_hi, sb.cfg_pw_lo, clock_us, '0, '0));
    end
    idle_on = 1'b1;
    r = mkreq(ACT_LOGIN, 0, '0, '0, 1, sb.cfg_pw_hi, sb.cfg_pw_lo, clock_us, tk[0], tk[1]);
    send(r);
    send(mkreq(ACT_CHECK, 1, tk[0], tk[1], 0, '0, '0, clock_us, '0, '0));

    drain();
    repeat (NSLOT + 16) @(negedge clk_i);
    $display("covered %0d requests and %0d replies: %0d tokens issued, %0d evictions,",
             sb.n_requests, sb.n_replies, sb.n_issued, sb.n_evicted);
    $display("%0d sessions aged out in scans, failure counter peaked at %0d; %0d mismatches",
             sb.n_aged, sb.peak_failures, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/stt_pkg.sv
design/stt_ctrl.sv
design/stt_dp.sv
design/session_token_table_with_expiry.sv
bench/session_token_table_with_expiry_tb.sv
